// File: hdl/subtitle_alpha_blend_yuv_assert.svh
// Assertion macros used by the subtitle blender checker.
`ifndef SUBTITLE_ALPHA_BLEND_YUV_ASSERT_SVH
`define SUBTITLE_ALPHA_BLEND_YUV_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SABYUV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SABYUV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sabyuv_pkg.sv
// Types and constants of the subtitle alpha blender.
`default_nettype none

package sabyuv_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_HORIZ_SUB = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VERT_SUB  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SHIFT     = 2'd2;

	// item kinds
	localparam logic KIND_LUMA   = 1'b0;
	localparam logic KIND_CHROMA = 1'b1;

	// blend constants
	localparam logic [7:0] ALPHA_FULL = 8'd255;
	localparam logic [7:0] ALPHA_NONE = 8'd0;

	typedef struct packed {
		logic        kind;
		logic [15:0] dst_first;
		logic [15:0] dst_second;
		logic [7:0]  sub_first;
		logic [7:0]  sub_second;
		logic [7:0]  alpha_here;
		logic [7:0]  alpha_right;
		logic [7:0]  alpha_below;
		logic [7:0]  alpha_diag;
		logic        has_right;
		logic        has_below;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_first;
		logic [15:0] out_second;
	} out_item_t;

	typedef struct packed {
		logic       horiz_subsampled;
		logic       vert_subsampled;
		logic [3:0] extra_shift;
	} cfg_regs_t;

endpackage

`default_nettype wire

// File: hdl/sabyuv_alpha.sv
// Chroma alpha averaging over the subtitle alpha neighborhood.
`default_nettype none

module sabyuv_alpha
	import sabyuv_pkg::*;
(
	input  var in_item_t  item,
	input  var cfg_regs_t cfg,
	output logic [7:0]    alpha_chroma
);

	logic [9:0] sum_quad;
	logic [8:0] sum_right;
	logic [8:0] sum_below;
	logic [7:0] alpha_h;
	logic [7:0] alpha_v;
	logic [8:0] sum_hv;
	logic       use_right;
	logic       use_below;

	// average over the four positions, or over the horizontal and vertical pairs, or pass alpha_here when unsubsampled
	always_comb begin
		use_right = cfg.horiz_subsampled & item.has_right;
		use_below = cfg.vert_subsampled & item.has_below;
		sum_quad  = 10'(item.alpha_here) + 10'(item.alpha_right)
			+ 10'(item.alpha_below) + 10'(item.alpha_diag);
		sum_right = 9'(item.alpha_here) + 9'(item.alpha_right);
		sum_below = 9'(item.alpha_here) + 9'(item.alpha_below);
		alpha_h   = use_right ? sum_right[8:1] : item.alpha_here;
		alpha_v   = use_below ? sum_below[8:1] : item.alpha_here;
		sum_hv    = 9'(alpha_h) + 9'(alpha_v);
		if (use_right && use_below) begin
			alpha_chroma = sum_quad[9:2];
		end else if (cfg.horiz_subsampled || cfg.vert_subsampled) begin
			alpha_chroma = sum_hv[8:1];
		end else begin
			alpha_chroma = item.alpha_here;
		end
	end

endmodule

`default_nettype wire

// File: hdl/sabyuv_lane.sv
// One blend lane: products in one stage, rounding divide by 255 after it.
`default_nettype none

module sabyuv_lane
	import sabyuv_pkg::*;
#(
	parameter int unsigned MAX_SAMPLE_BITS = 16
) (
	input  wire         clk,
	input  wire  [15:0] dst,
	input  wire  [7:0]  sub,
	input  wire  [7:0]  alpha,
	input  wire  [3:0]  shift,
	output logic [15:0] blended
);

	localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << MAX_SAMPLE_BITS) - 32'd1);

	logic [15:0] src;
	logic [23:0] prod_keep_s2;
	logic [23:0] prod_sub_s2;
	logic [15:0] dst_s2;
	logic [15:0] src_s2;
	logic        zero_s2;
	logic        full_s2;
	logic [24:0] mix_sum;
	logic [25:0] mix_round;
	logic [33:0] mix_scaled;
	logic [15:0] mix;

	assign src = 16'({8'd0, sub} << shift);

	// register both weighted products
	always_ff @(posedge clk) begin
		prod_keep_s2 <= dst * 24'(ALPHA_FULL - alpha);
		prod_sub_s2  <= src * 24'(alpha);
		dst_s2       <= dst;
		src_s2       <= src;
		zero_s2      <= (alpha == ALPHA_NONE);
		full_s2      <= (alpha == ALPHA_FULL);
	end

	// divide by 255 as (x+128)*257>>16, then pick the end cases
	always_comb begin
		mix_sum    = 25'(prod_keep_s2) + 25'(prod_sub_s2);
		mix_round  = 26'(mix_sum) + 26'd128;
		mix_scaled = {mix_round, 8'd0} + 34'(mix_round);
		mix        = mix_scaled[31:16];
		if (zero_s2) begin
			blended = dst_s2 & SAMPLE_MASK;
		end else if (full_s2) begin
			blended = src_s2 & SAMPLE_MASK;
		end else begin
			blended = mix & SAMPLE_MASK;
		end
	end

endmodule

`default_nettype wire

// File: hdl/subtitle_alpha_blend_yuv.sv
// Subtitle overlay blender for planar YUV video: two blend lanes and a merge stage.
// Pipeline: the request is registered into s1, the lane products into s2, the merged result into s3.
// Throughput: one request per cycle; busy stays low, set by the two lanes
// running side by side through a three-stage pipeline.
// Reset clears the pipeline valids and sets horiz/vert subsampling to 1, shift to 0.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none

module subtitle_alpha_blend_yuv
	import sabyuv_pkg::*;
#(
	parameter int unsigned MAX_SAMPLE_BITS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  var in_item_t           item,
	output logic                   result_valid,
	output out_item_t              result,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_INDEX_W-1:0] cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [3:0] SHIFT_MAX = 4'(MAX_SAMPLE_BITS - 8);

	cfg_regs_t   cfg_q;
	logic [7:0]  alpha_chroma;
	logic [3:0]  shift_sat;
	logic        accept;

	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] dst_first_s1;
	logic [15:0] dst_second_s1;
	logic [7:0]  sub_first_s1;
	logic [7:0]  sub_second_s1;
	logic [7:0]  alpha_first_s1;
	logic [7:0]  alpha_second_s1;
	logic [3:0]  shift_s1;

	logic        valid_s2;
	logic        kind_s2;
	logic [15:0] dst_second_s2;

	logic [15:0] lane_first;
	logic [15:0] lane_second;

	logic        valid_s3;
	out_item_t   result_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.horiz_subsampled <= 1'b1;
			cfg_q.vert_subsampled  <= 1'b1;
			cfg_q.extra_shift      <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HORIZ_SUB: cfg_q.horiz_subsampled <= cfg_data[0];
				REG_VERT_SUB:  cfg_q.vert_subsampled  <= cfg_data[0];
				REG_SHIFT:     cfg_q.extra_shift      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	sabyuv_alpha u_alpha (
		.item         (item),
		.cfg          (cfg_q),
		.alpha_chroma (alpha_chroma)
	);

	assign shift_sat = (cfg_q.extra_shift > SHIFT_MAX) ? SHIFT_MAX : cfg_q.extra_shift;

	// advance valids through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// capture the request with its lane alphas
	always_ff @(posedge clk) begin
		kind_s1         <= item.kind;
		dst_first_s1    <= item.dst_first;
		dst_second_s1   <= item.dst_second;
		sub_first_s1    <= item.sub_first;
		sub_second_s1   <= item.sub_second;
		alpha_first_s1  <= (item.kind == KIND_CHROMA) ? alpha_chroma : item.alpha_here;
		alpha_second_s1 <= alpha_chroma;
		shift_s1        <= shift_sat;
		kind_s2         <= kind_s1;
		dst_second_s2   <= dst_second_s1;
	end

	sabyuv_lane #(
		.MAX_SAMPLE_BITS (MAX_SAMPLE_BITS)
	) u_lane_first (
		.clk     (clk),
		.dst     (dst_first_s1),
		.sub     (sub_first_s1),
		.alpha   (alpha_first_s1),
		.shift   (shift_s1),
		.blended (lane_first)
	);

	sabyuv_lane #(
		.MAX_SAMPLE_BITS (MAX_SAMPLE_BITS)
	) u_lane_second (
		.clk     (clk),
		.dst     (dst_second_s1),
		.sub     (sub_second_s1),
		.alpha   (alpha_second_s1),
		.shift   (shift_s1),
		.blended (lane_second)
	);

	// merge lanes; luma passes the second video sample through
	always_ff @(posedge clk) begin
		result_s3.out_first  <= lane_first;
		result_s3.out_second <= (kind_s2 == KIND_CHROMA) ? lane_second : dst_second_s2;
	end

	assign result_valid = valid_s3;
	assign result       = result_s3;

endmodule

`default_nettype wire

// File: hdl/sabyuv_checker.sv
// Port-level checker for the subtitle blender, bound to the top level.
`default_nettype none

`include "subtitle_alpha_blend_yuv_assert.svh"

module sabyuv_checker
	import sabyuv_pkg::*;
#(
	parameter int unsigned MAX_SAMPLE_BITS = 16
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   start,
	input wire                   busy,
	input var in_item_t          item,
	input wire                   result_valid,
	input var out_item_t         result
);

	localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << MAX_SAMPLE_BITS) - 32'd1);

	// every accepted request strobes a result
	`SABYUV_ASSERT_NXT(a_result_follows, start && !busy, ##2 result_valid, "request produced no result")

	// no result without an earlier accepted request
	`SABYUV_ASSERT_IMP(a_no_spurious, result_valid, $past(start && !busy, 3), "result without request")

	// luma request passes the second video sample unchanged
	`SABYUV_ASSERT_IMP(a_luma_pass, result_valid && $past(item.kind == KIND_LUMA, 3), result.out_second == $past(item.dst_second, 3), "luma second sample changed")

	// zero alpha on luma keeps the video sample
	`SABYUV_ASSERT_IMP(a_luma_keep, result_valid && $past(item.kind == KIND_LUMA && item.alpha_here == ALPHA_NONE, 3), result.out_first == ($past(item.dst_first, 3) & SAMPLE_MASK), "transparent luma altered")

endmodule

bind subtitle_alpha_blend_yuv sabyuv_checker #(
	.MAX_SAMPLE_BITS (MAX_SAMPLE_BITS)
) u_checker (.*);

`default_nettype wire
